// File: rtl/lpfd_pkg.sv
`timescale 1ns / 1ps
package lpfd_pkg;

  localparam int LEN_W = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [LEN_W-1:0] HDR_BYTES       = 32'd20;
  localparam logic [LEN_W-1:0] OFS_MAJOR       = 32'd4;
  localparam logic [LEN_W-1:0] OFS_MINOR       = 32'd6;
  localparam logic [LEN_W-1:0] OFS_TYPE        = 32'd8;
  localparam logic [LEN_W-1:0] OFS_FLAGS       = 32'd10;
  localparam logic [LEN_W-1:0] OFS_RID         = 32'd12;
  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 32'd65536;

  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_LEN_SHORT = 3'd1;
  localparam logic [2:0] STATUS_LEN_LONG  = 3'd2;
  localparam logic [2:0] STATUS_POISONED  = 3'd3;
  localparam logic [2:0] STATUS_MAX_SHORT = 3'd4;

  typedef enum logic [1:0] {
    OP_FIELD,
    OP_HEADER,
    OP_PAYLOAD,
    OP_ERROR
  } cmd_op_t;

  typedef enum logic [1:0] {
    FLD_MAJOR,
    FLD_MINOR,
    FLD_TYPE,
    FLD_FLAGS
  } fld_sel_t;

  // one classified request from the front to the back
  typedef struct packed {
    cmd_op_t          op;
    fld_sel_t         fld;
    logic             rid;     // byte belongs to the request id
    logic [7:0]       data;
    logic [2:0]       status;
    logic [LEN_W-1:0] length;
    logic             last;
  } cmd_t;

endpackage

// File: rtl/lpfd_front.sv
`timescale 1ns / 1ps
module lpfd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [7:0]           data_byte,
  input  logic                 cfg_write,
  input  logic [31:0]          cfg_data,
  input  logic                 q_full,
  output logic                 push,
  output lpfd_pkg::cmd_t       cmd
);
  import lpfd_pkg::*;

  logic             poisoned, poisoned_next;
  logic [LEN_W-1:0] pos, pos_next;
  logic [LEN_W-1:0] held_length, held_length_next;
  logic [LEN_W-1:0] frame_limit;
  logic [LEN_W-1:0] len_shift;
  logic [LEN_W-1:0] pos_inc;
  logic             accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign len_shift = {held_length[LEN_W-9:0], data_byte};
  assign pos_inc   = pos + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= MAX_FRAME_RESET;
    end else if (cfg_write) begin
      frame_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poisoned    <= 1'b0;
      pos         <= '0;
      held_length <= '0;
    end else begin
      poisoned    <= poisoned_next;
      pos         <= pos_next;
      held_length <= held_length_next;
    end
  end

  always_comb begin
    poisoned_next    = poisoned;
    pos_next         = pos;
    held_length_next = held_length;
    push             = 1'b0;
    cmd.op           = OP_ERROR;
    cmd.fld          = FLD_MAJOR;
    cmd.rid          = 1'b0;
    cmd.data         = data_byte;
    cmd.status       = STATUS_OK;
    cmd.length       = '0;
    cmd.last         = 1'b0;
    if (accept) begin
      if (func == FUNC_CLEAR) begin
        poisoned_next    = 1'b0;
        pos_next         = '0;
        held_length_next = '0;
      end else if (poisoned) begin
        push       = 1'b1;
        cmd.status = STATUS_POISONED;
      end else if (frame_limit < HDR_BYTES) begin
        push             = 1'b1;
        cmd.status       = STATUS_MAX_SHORT;
        poisoned_next    = 1'b1;
        pos_next         = '0;
        held_length_next = '0;
      end else if (pos < OFS_MAJOR) begin
        if (pos == OFS_MAJOR - 32'd1 &&
            (len_shift < HDR_BYTES || len_shift > frame_limit)) begin
          push             = 1'b1;
          cmd.status       = (len_shift < HDR_BYTES) ? STATUS_LEN_SHORT : STATUS_LEN_LONG;
          cmd.length       = len_shift;
          poisoned_next    = 1'b1;
          pos_next         = '0;
          held_length_next = '0;
        end else begin
          held_length_next = len_shift;
          pos_next         = pos_inc;
        end
      end else if (held_length > frame_limit) begin
        // maximum lowered mid-frame
        push             = 1'b1;
        cmd.status       = STATUS_LEN_LONG;
        cmd.length       = held_length;
        poisoned_next    = 1'b1;
        pos_next         = '0;
        held_length_next = '0;
      end else if (pos < HDR_BYTES) begin
        push       = 1'b1;
        cmd.length = held_length;
        if (pos < OFS_MINOR) begin
          cmd.fld = FLD_MAJOR;
        end else if (pos < OFS_TYPE) begin
          cmd.fld = FLD_MINOR;
        end else if (pos < OFS_FLAGS) begin
          cmd.fld = FLD_TYPE;
        end else if (pos < OFS_RID) begin
          cmd.fld = FLD_FLAGS;
        end else begin
          cmd.rid = 1'b1;
        end
        if (pos == HDR_BYTES - 32'd1) begin
          cmd.op   = OP_HEADER;
          cmd.last = (held_length == HDR_BYTES);
          if (held_length == HDR_BYTES) begin
            pos_next         = '0;
            held_length_next = '0;
          end else begin
            pos_next = HDR_BYTES;
          end
        end else begin
          cmd.op   = OP_FIELD;
          pos_next = pos_inc;
        end
      end else begin
        push       = 1'b1;
        cmd.op     = OP_PAYLOAD;
        cmd.length = held_length;
        cmd.last   = (pos_inc >= held_length);
        if (pos_inc >= held_length) begin
          pos_next         = '0;
          held_length_next = '0;
        end else begin
          pos_next = pos_inc;
        end
      end
    end
  end

endmodule

// File: rtl/lpfd_queue.sv
`timescale 1ns / 1ps
module lpfd_queue #(
  parameter int DEPTH = lpfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpfd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lpfd_pkg::cmd_t head_cmd
);
  import lpfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lpfd_back.sv
`timescale 1ns / 1ps
module lpfd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  lpfd_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     kind,
  output logic [2:0]     status,
  output logic [31:0]    frame_length,
  output logic [15:0]    version_major,
  output logic [15:0]    version_minor,
  output logic [15:0]    message_kind,
  output logic [15:0]    frame_flags,
  output logic [63:0]    request_tag,
  output logic [7:0]     payload_byte,
  output logic           last
);
  import lpfd_pkg::*;

  logic [15:0] held_major, held_minor, held_type, held_flags;
  logic [63:0] held_rid;
  logic [63:0] rid_shift;
  logic        slot_free;
  logic        emits;
  logic [1:0]  kind_next;
  logic [15:0] major_next, minor_next, type_next, flags_next;
  logic [63:0] tag_next;
  logic [7:0]  payload_next;

  assign slot_free = !out_valid || out_ready;
  assign pop       = head_valid && slot_free;
  assign emits     = (head_cmd.op != OP_FIELD);
  assign rid_shift = {held_rid[55:0], head_cmd.data};

  // header word assembly; every word is fully rewritten by each new header
  always_ff @(posedge clk) begin
    if (pop && (head_cmd.op == OP_FIELD || head_cmd.op == OP_HEADER)) begin
      if (head_cmd.rid) begin
        held_rid <= rid_shift;
      end else begin
        case (head_cmd.fld)
          FLD_MAJOR: held_major <= {held_major[7:0], head_cmd.data};
          FLD_MINOR: held_minor <= {held_minor[7:0], head_cmd.data};
          FLD_TYPE:  held_type  <= {held_type[7:0], head_cmd.data};
          FLD_FLAGS: held_flags <= {held_flags[7:0], head_cmd.data};
          default:   held_major <= held_major;
        endcase
      end
    end
  end

  // result fields by request kind; unused fields are zero
  always_comb begin
    kind_next    = KIND_ERROR;
    major_next   = '0;
    minor_next   = '0;
    type_next    = '0;
    flags_next   = '0;
    tag_next     = '0;
    payload_next = '0;
    case (head_cmd.op)
      OP_HEADER: begin
        kind_next  = KIND_HEADER;
        major_next = held_major;
        minor_next = held_minor;
        type_next  = held_type;
        flags_next = held_flags;
        tag_next   = rid_shift;
      end
      OP_PAYLOAD: begin
        kind_next    = KIND_PAYLOAD;
        payload_next = head_cmd.data;
      end
      default: begin
        kind_next = KIND_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= pop && emits;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      kind          <= kind_next;
      status        <= head_cmd.status;
      frame_length  <= head_cmd.length;
      version_major <= major_next;
      version_minor <= minor_next;
      message_kind  <= type_next;
      frame_flags   <= flags_next;
      request_tag   <= tag_next;
      payload_byte  <= payload_next;
      last          <= head_cmd.last;
    end
  end

endmodule

// File: rtl/length_prefixed_frame_decoder.sv
`timescale 1ns / 1ps
// length-prefixed frame decoder: takes one stream byte per cycle (func 0) or a clear
// request (func 1) while the command queue has room, and turns big-endian frames
// with a 20-byte header (32-bit total length, major, minor, type, flags, 64-bit
// request id) into one header result once the header is complete, then one result
// per payload byte with last on the final byte (on the header itself for a frame
// with no payload). a length below 20, a length above the frame limit (rechecked on
// every byte) or a limit below 20 gives an error result and poisons the decoder;
// poisoned bytes give status 3 until a clear request. payload streams out as it
// arrives, so a truncated frame never gets last. throughput is one request per cycle
// while the queue has room, as the front updates its byte position and length
// registers on each request; a result passes through the command queue and then the
// output register. the frame limit resets to 65536 and is written through
// cfg_write/cfg_data by the user only while no request is in flight; the block has no check.
module length_prefixed_frame_decoder #(
  parameter int QUEUE_DEPTH = lpfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  data_byte,
  // configuration
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic [31:0] frame_length,
  output logic [15:0] version_major,
  output logic [15:0] version_minor,
  output logic [15:0] message_kind,
  output logic [15:0] frame_flags,
  output logic [63:0] request_tag,
  output logic [7:0]  payload_byte,
  output logic        last
);
  import lpfd_pkg::*;

  // front to queue
  logic q_full;
  logic push;
  cmd_t push_cmd;

  // queue to back
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // front: tracks byte position, length and poison state, classifies each byte
  lpfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_byte (data_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // short command queue so the front keeps taking bytes while a result waits
  lpfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: assembles header words and forms the registered result
  lpfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .status        (status),
    .frame_length  (frame_length),
    .version_major (version_major),
    .version_minor (version_minor),
    .message_kind  (message_kind),
    .frame_flags   (frame_flags),
    .request_tag   (request_tag),
    .payload_byte  (payload_byte),
    .last          (last)
  );

endmodule

// File: sim/length_prefixed_frame_decoder_test.sv
`timescale 1ns / 1ps
module length_prefixed_frame_decoder_test;
  import lpfd_pkg::*;

  // cycles with no accepted request on either channel before the run is abandoned
  localparam int IDLE_LIMIT = 2000;
  // rough size of the random part, spread over the frame limit settings below
  localparam int RANDOM_ITEMS = 800;
  // longest payload used while the maximum is far above the header size
  localparam int unsigned LONG_PAYLOAD = 300;

  // one decoded result, laid out field by field as the ports carry it
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [31:0] frame_length;
    logic [15:0] version_major;
    logic [15:0] version_minor;
    logic [15:0] message_kind;
    logic [15:0] frame_flags;
    logic [63:0] request_tag;
    logic [7:0]  payload_byte;
    logic        last;
  } frame_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_PATTERN,
    RX_HEAVY
  } rx_mode_t;

  // deframer shadow: follows every accepted request and queues what the block
  // has to answer, then checks the answers in order
  class deframe_scoreboard;
    logic [31:0]   max_frame;
    bit            poisoned;
    logic [31:0]   position;
    logic [31:0]   held_length;
    logic [15:0]   held_major;
    logic [15:0]   held_minor;
    logic [15:0]   held_type;
    logic [15:0]   held_flags;
    logic [63:0]   held_rid;
    frame_result_t decoded_q[$];
    int            mismatches;
    int            headers_seen;
    int            payload_seen;
    int            errors_seen;

    function new();
      max_frame    = MAX_FRAME_RESET;
      poisoned     = 1'b0;
      mismatches   = 0;
      headers_seen = 0;
      payload_seen = 0;
      errors_seen  = 0;
      drop_frame();
    endfunction

    function void drop_frame();
      position    = '0;
      held_length = '0;
      held_major  = '0;
      held_minor  = '0;
      held_type   = '0;
      held_flags  = '0;
      held_rid    = '0;
    endfunction

    function void raise_error(logic [2:0] code, logic [31:0] len);
      frame_result_t r;
      r              = '0;
      r.kind         = KIND_ERROR;
      r.status       = code;
      r.frame_length = len;
      decoded_q      = {decoded_q, r};
      drop_frame();
      poisoned = 1'b1;
    endfunction

    function void take_request(logic fn, logic [7:0] b);
      frame_result_t r;
      logic [31:0]   pos;
      r = '0;
      if (fn == FUNC_CLEAR) begin
        drop_frame();
        poisoned = 1'b0;
        return;
      end
      if (poisoned) begin
        r.kind    = KIND_ERROR;
        r.status  = STATUS_POISONED;
        decoded_q = {decoded_q, r};
        return;
      end
      if (max_frame < HDR_BYTES) begin
        raise_error(STATUS_MAX_SHORT, '0);
        return;
      end
      pos = position;
      if (pos < OFS_MAJOR) begin
        held_length = {held_length[23:0], b};
        if (pos == OFS_MAJOR - 1) begin
          if (held_length < HDR_BYTES) begin
            raise_error(STATUS_LEN_SHORT, held_length);
            return;
          end
          if (held_length > max_frame) begin
            raise_error(STATUS_LEN_LONG, held_length);
            return;
          end
        end
        position = pos + 1;
        return;
      end
      // the length is rechecked on every later byte of the frame
      if (held_length > max_frame) begin
        raise_error(STATUS_LEN_LONG, held_length);
        return;
      end
      if (pos < HDR_BYTES) begin
        if (pos < OFS_MINOR) held_major = {held_major[7:0], b};
        else if (pos < OFS_TYPE) held_minor = {held_minor[7:0], b};
        else if (pos < OFS_FLAGS) held_type = {held_type[7:0], b};
        else if (pos < OFS_RID) held_flags = {held_flags[7:0], b};
        else held_rid = {held_rid[55:0], b};
        if (pos != HDR_BYTES - 1) begin
          position = pos + 1;
          return;
        end
        r.kind          = KIND_HEADER;
        r.status        = STATUS_OK;
        r.frame_length  = held_length;
        r.version_major = held_major;
        r.version_minor = held_minor;
        r.message_kind  = held_type;
        r.frame_flags   = held_flags;
        r.request_tag   = held_rid;
        r.last          = (held_length == HDR_BYTES);
        decoded_q       = {decoded_q, r};
        if (r.last) drop_frame();
        else position = HDR_BYTES;
        return;
      end
      r.kind         = KIND_PAYLOAD;
      r.status       = STATUS_OK;
      r.frame_length = held_length;
      r.payload_byte = b;
      if ({1'b0, pos} + 33'd1 >= {1'b0, held_length}) begin
        r.last = 1'b1;
        drop_frame();
      end else begin
        position = pos + 1;
      end
      decoded_q = {decoded_q, r};
    endfunction

    function void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: kind %0d status %0d", got.kind, got.status);
        mismatches++;
        return;
      end
      want = decoded_q.pop_front();
      case (want.kind)
        KIND_HEADER:  headers_seen++;
        KIND_PAYLOAD: payload_seen++;
        default:      errors_seen++;
      endcase
      compare_field("kind", want.kind, got.kind);
      compare_field("status", want.status, got.status);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("version_major", want.version_major, got.version_major);
      compare_field("version_minor", want.version_minor, got.version_minor);
      compare_field("message_kind", want.message_kind, got.message_kind);
      compare_field("frame_flags", want.frame_flags, got.frame_flags);
      compare_field("request_tag", want.request_tag, got.request_tag);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        func      = FUNC_DATA;
  logic [7:0]  data_byte = 8'h00;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data  = 32'h0;
  logic        out_ready = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [31:0] frame_length;
  logic [15:0] version_major;
  logic [15:0] version_minor;
  logic [15:0] message_kind;
  logic [15:0] frame_flags;
  logic [63:0] request_tag;
  logic [7:0]  payload_byte;
  logic        last;

  deframe_scoreboard sb;

  // sender burst bookkeeping and run statistics
  int burst_left    = 0;
  int sent_items    = 0;
  int phases_run    = 0;
  int idle_cycles   = 0;

  // receiver stall pattern state
  int unsigned mode_cycles   = 0;
  rx_mode_t    rx_mode       = RX_OPEN;
  logic [7:0]  ready_pattern = 8'hFF;

  length_prefixed_frame_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .data_byte     (data_byte),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .status        (status),
    .frame_length  (frame_length),
    .version_major (version_major),
    .version_minor (version_minor),
    .message_kind  (message_kind),
    .frame_flags   (frame_flags),
    .request_tag   (request_tag),
    .payload_byte  (payload_byte),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: switches at random between always ready, light random stalls, a
  // rotating ready pattern and heavy random stalls
  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      mode_cycles   <= $urandom_range(50, 300);
      rx_mode       <= rx_mode_t'($urandom_range(0, 3));
      ready_pattern <= 8'($urandom_range(0, 255)) | 8'h01;
      out_ready     <= 1'b1;
    end else begin
      mode_cycles <= mode_cycles - 1;
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_LIGHT:   out_ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: begin
          out_ready     <= ready_pattern[0];
          ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
        end
        default:    out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // both channels are sampled here; the request is noted before the result is
  // checked so a same-cycle answer would still find its expectation
  always @(posedge clk) begin : watch_channels
    frame_result_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.take_request(func, data_byte);
      if (out_valid && out_ready) begin
        got = {kind, status, frame_length, version_major, version_minor,
               message_kind, frame_flags, request_tag, payload_byte, last};
        sb.check_result(got);
      end
    end
  end

  // watchdog on stretches with no accepted request or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no progress for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, sb.decoded_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // one request: valid stays high from one request to the next inside a burst; this
  // task drops it only for the gap that may come before a new burst
  task automatic send_item(input logic fn, input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    func      <= fn;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // big-endian length field
  task automatic send_length(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_item(FUNC_DATA, len[8*i +: 8]);
  endtask

  // stop sending and wait until every answer is in and the pipeline is empty,
  // including requests that give no result
  task automatic drain_requests();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called while drained; the shadow picks up the new maximum at once
  task automatic write_max(input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.max_frame = value;
  endtask

  // one random sequence that always leaves the decoder idle: a good frame, a frame
  // cut short and cleared, a bad length with poisoned bytes, or plain noise
  task automatic send_frame();
    int unsigned pick;
    int unsigned room;
    int unsigned payload_len;
    int unsigned total;
    int unsigned cut;
    logic [31:0] len;
    logic [7:0]  hdr[16];
    int unsigned fill;
    pick = $urandom_range(0, 99);
    // with the maximum below the header every byte is an error anyway
    if (sb.max_frame < HDR_BYTES) pick = 95;
    if (pick < 83) begin
      room = sb.max_frame - HDR_BYTES;
      if (room > LONG_PAYLOAD) room = LONG_PAYLOAD;
      case ($urandom_range(0, 9))
        0:       payload_len = 0;
        1:       payload_len = room;
        default: payload_len = $urandom_range(0, (room > 40) ? 40 : room);
      endcase
      len   = HDR_BYTES + payload_len;
      total = len;
      // truncated frames stop somewhere inside and get cleared
      cut   = (pick < 75) ? total : $urandom_range(1, total - 1);
      fill  = $urandom_range(0, 7);
      foreach (hdr[i]) begin
        hdr[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      end
      for (int unsigned i = 0; i < cut; i++) begin
        if (i < 4) send_item(FUNC_DATA, len[31 - 8*i -: 8]);
        else if (i < HDR_BYTES) send_item(FUNC_DATA, hdr[i - 4]);
        else send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
      end
      if (cut != total) send_item(FUNC_CLEAR, 8'($urandom_range(0, 255)));
    end else if (pick < 91) begin
      if (sb.max_frame == 32'hFFFF_FFFF || $urandom_range(0, 2) == 0)
        len = $urandom_range(0, HDR_BYTES - 1);
      else
        len = $urandom_range(sb.max_frame + 32'd1, 32'hFFFF_FFFF);
      send_length(len);
      repeat ($urandom_range(0, 3)) send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
      send_item(FUNC_CLEAR, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_item(($urandom_range(0, 3) == 0) ? FUNC_CLEAR : FUNC_DATA,
                  8'($urandom_range(0, 255)));
      end
      send_item(FUNC_CLEAR, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [31:0] plan_max[8];
    int          plan_items[8];
    int          phase_end;
    sb = new();
    // settings for the random part: the reset value, the header size and one above,
    // the top of the range, a small one, two below the header and a random one
    plan_max[0] = MAX_FRAME_RESET;
    plan_max[1] = HDR_BYTES;
    plan_max[2] = 32'hFFFF_FFFF;
    plan_max[3] = HDR_BYTES + 1;
    plan_max[4] = $urandom_range(HDR_BYTES, 400);
    plan_max[5] = 32'h0;
    plan_max[6] = HDR_BYTES - 1;
    plan_max[7] = $urandom_range(HDR_BYTES, 32'hFFFF_FFFF);
    foreach (plan_items[i]) begin
      plan_items[i] = (plan_max[i] < HDR_BYTES) ? 30 : (RANDOM_ITEMS - 60) / 6;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: clear on an idle decoder, then a length below the header
    write_max(32'd64);
    send_item(FUNC_CLEAR, 8'hA5);
    send_length(HDR_BYTES - 1);
    // poisoned byte, then clear
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_CLEAR, 8'h00);
    // all-ones length is above any maximum but the top one
    send_length(32'hFFFF_FFFF);
    send_item(FUNC_CLEAR, 8'hFF);
    // start a 40-byte frame, lower the maximum under it, next byte hits the recheck
    send_length(32'd40);
    send_item(FUNC_DATA, 8'h7E);
    drain_requests();
    write_max(32'd30);
    send_item(FUNC_DATA, 8'h81);
    send_item(FUNC_CLEAR, 8'h00);
    drain_requests();
    // maximum of zero: error on the first byte, then poisoned
    write_max(32'h0);
    send_item(FUNC_DATA, 8'hFF);
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_CLEAR, 8'h00);
    drain_requests();
    // one short of the header size
    write_max(HDR_BYTES - 1);
    send_item(FUNC_DATA, 8'h55);
    send_item(FUNC_CLEAR, 8'h00);
    drain_requests();

    // random part, one phase per maximum setting
    foreach (plan_max[i]) begin
      write_max(plan_max[i]);
      phase_end = sent_items + plan_items[i];
      while (sent_items < phase_end) send_frame();
      drain_requests();
      phases_run++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests over %0d frame limit settings plus directed cases",
             sent_items, phases_run);
    $display("checked %0d headers, %0d payload bytes, %0d errors",
             sb.headers_seen, sb.payload_seen, sb.errors_seen);
    if (sb.mismatches == 0 && sb.decoded_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
